/* sv/move_to_front_list_table_macros.svh */
// assertion helpers for the list table checker
`ifndef MOVE_TO_FRONT_LIST_TABLE_MACROS_SVH
`define MOVE_TO_FRONT_LIST_TABLE_MACROS_SVH

// same-cycle implication
`define MTFL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list table assertion failed");

// next-cycle implication
`define MTFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list table assertion failed");

`endif

/* sv/mtfl_pkg.sv */
package mtfl_pkg;

   localparam int DEFAULT_DEPTH       = 16;
   localparam int DEFAULT_LABEL_CHARS = 8;

   typedef enum logic [2:0] {
      OP_ADD_END    = 3'd0,
      OP_ADD_FRONT  = 3'd1,
      OP_REMOVE     = 3'd2,
      OP_INS_BEFORE = 3'd3,
      OP_INS_AFTER  = 3'd4,
      OP_FIND       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_NO_MATCH = 2'd1,
      STAT_FULL     = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic   compare_en;
      logic   update_en;
      op_type op;
      logic   full;
      logic   found;
      logic   mtf;
   } cmd_type;

   // keep the low chars bytes up to the first zero byte
   function automatic logic [63:0] clean_label(input logic [63:0] raw, input int chars);
      logic [63:0] kept;
      logic        stop;
      kept = '0;
      stop = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (b >= chars || raw[8*b +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            kept[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return kept;
   endfunction

endpackage

/* sv/mtfl_cell.sv */
module mtfl_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5,
   parameter int LW  = 64
) (
   input  logic                clock,
   input  mtfl_pkg::cmd_type   cmd,
   input  logic [CW-1:0]       count,
   input  logic signed [31:0]  key,
   input  logic signed [31:0]  new_value,
   input  logic [LW-1:0]       new_label,
   input  logic signed [31:0]  left_value,
   input  logic [LW-1:0]       left_label,
   input  logic signed [31:0]  right_value,
   input  logic [LW-1:0]       right_label,
   input  logic signed [31:0]  found_value,
   input  logic [LW-1:0]       found_label,
   input  logic                seen_in,
   input  logic                prev_first,
   output logic signed [31:0]  value,
   output logic [LW-1:0]       label,
   output logic                first,
   output logic                seen_out
);
   import mtfl_pkg::*;

   logic signed [31:0] value_ff, value_in;
   logic [LW-1:0]      label_ff, label_in;
   logic               match_ff;
   logic               occupied;
   logic               take_new, take_left, take_right, take_found;

   assign occupied = CW'(IDX) < count;

   always_comb begin
      take_new   = 1'b0;
      take_left  = 1'b0;
      take_right = 1'b0;
      take_found = 1'b0;
      case (cmd.op)
         OP_ADD_END: begin
            take_new = !cmd.full && (count == CW'(IDX));
         end
         OP_ADD_FRONT: begin
            take_new  = !cmd.full && (IDX == 0);
            take_left = !cmd.full && (IDX != 0);
         end
         OP_REMOVE: begin
            take_right = first || seen_in;
         end
         OP_INS_BEFORE: begin
            take_new  = !cmd.full && first;
            take_left = !cmd.full && seen_in;
         end
         OP_INS_AFTER: begin
            take_new  = !cmd.full && prev_first;
            take_left = !cmd.full && seen_in && !prev_first;
         end
         OP_FIND: begin
            // head takes the found entry, cells up to the match slide down one
            take_found = cmd.mtf && cmd.found && (IDX == 0);
            take_left  = cmd.mtf && cmd.found && (IDX != 0) && !seen_in;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      value_in = value_ff;
      label_in = label_ff;
      if (take_new) begin
         value_in = new_value;
         label_in = new_label;
      end else if (take_left) begin
         value_in = left_value;
         label_in = left_label;
      end else if (take_right) begin
         value_in = right_value;
         label_in = right_label;
      end else if (take_found) begin
         value_in = found_value;
         label_in = found_label;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare_en) begin
         match_ff <= occupied && (value_ff == key);
      end
      if (cmd.update_en) begin
         value_ff <= value_in;
         label_ff <= label_in;
      end
   end

   assign value    = value_ff;
   assign label    = label_ff;
   assign first    = match_ff && !seen_in;
   assign seen_out = seen_in || match_ff;

endmodule

/* sv/move_to_front_list_table.sv */
// an item is taken at start when idle; its result strobes after the update state
// a new item is not taken while busy; busy is high for the one update cycle
// the compare runs in all cells at the accept edge, the shift in the next cycle
// reset: synchronous, clears the entry count, sequencer, strobe and move-to-front
// results cannot be stalled; each is shown for exactly one cycle
module move_to_front_list_table #(
   parameter int DEPTH       = mtfl_pkg::DEFAULT_DEPTH,
   parameter int LABEL_CHARS = mtfl_pkg::DEFAULT_LABEL_CHARS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic signed [31:0]     req_search_key,
   input  logic signed [31:0]     req_new_value,
   input  logic [63:0]            req_new_label,
   output logic                   rsp_strobe,
   output mtfl_pkg::status_type   rsp_status,
   output logic [4:0]             rsp_compare_count,
   output logic [4:0]             rsp_entry_total,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_move_to_front_enable
);
   import mtfl_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int LW = 8 * LABEL_CHARS;

   state_type          state_ff, state_in;
   logic               accept, update_en;
   logic               mtf_ff;
   logic [CW-1:0]      count_ff, count_in;
   op_type             op_ff;
   logic signed [31:0] value_ff;
   logic [LW-1:0]      label_ff;
   logic [63:0]        clean;

   logic               strobe_ff;
   status_type         status_ff, status_in;
   logic [4:0]         compares_ff, compares_in;
   logic [4:0]         total_ff;

   cmd_type            cmd;
   logic signed [31:0] cell_value [DEPTH];
   logic [LW-1:0]      cell_label [DEPTH];
   logic [DEPTH-1:0]   cell_first;
   logic [DEPTH:0]     seen;
   logic [DEPTH:0]     first_chain;
   logic signed [31:0] found_value;
   logic [LW-1:0]      found_label;
   logic [IW-1:0]      found_pos;
   logic               found, full;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign clean     = clean_label(req_new_label, LABEL_CHARS);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      update_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
         end
         S_UPDATE: begin
            busy      = 1'b1;
            update_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mtf_ff    <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= update_en;
         if (csr_valid && csr_ready) begin
            mtf_ff <= csr_move_to_front_enable;
         end
         if (update_en) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_opcode);
         value_ff <= req_new_value;
         label_ff <= clean[LW-1:0];
      end
      if (update_en) begin
         status_ff   <= status_in;
         compares_ff <= compares_in;
         total_ff    <= 5'(count_in);
      end
   end

   assign full  = count_ff == CW'(DEPTH);
   assign found = seen[DEPTH];

   assign cmd.compare_en = accept;
   assign cmd.update_en  = update_en;
   assign cmd.op         = op_ff;
   assign cmd.full       = full;
   assign cmd.found      = found;
   assign cmd.mtf        = mtf_ff;

   assign seen[0]        = 1'b0;
   assign first_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_value, right_value;
      logic [LW-1:0]      left_label, right_label;
      if (i == 0) begin : g_head
         assign left_value = value_ff;
         assign left_label = label_ff;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_label = cell_label[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
         assign right_label = cell_label[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_label = cell_label[i+1];
      end

      mtfl_cell #(
         .IDX (i),
         .CW  (CW),
         .LW  (LW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .key         (req_search_key),
         .new_value   (value_ff),
         .new_label   (label_ff),
         .left_value  (left_value),
         .left_label  (left_label),
         .right_value (right_value),
         .right_label (right_label),
         .found_value (found_value),
         .found_label (found_label),
         .seen_in     (seen[i]),
         .prev_first  (first_chain[i]),
         .value       (cell_value[i]),
         .label       (cell_label[i]),
         .first       (cell_first[i]),
         .seen_out    (seen[i+1])
      );
      assign first_chain[i+1] = cell_first[i];
   end

   // at most one cell is first, so plain or-ing selects it
   always_comb begin
      found_value = '0;
      found_label = '0;
      found_pos   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_first[i]) begin
            found_value = found_value | cell_value[i];
            found_label = found_label | cell_label[i];
            found_pos   = found_pos | IW'(i);
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      status_in   = STAT_DONE;
      compares_in = '0;
      case (op_ff)
         OP_ADD_END, OP_ADD_FRONT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_REMOVE: begin
            if (!found) begin
               status_in = STAT_NO_MATCH;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (full) begin
               status_in = STAT_FULL;
            end else if (!found) begin
               status_in = STAT_NO_MATCH;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_FIND: begin
            if (!found) begin
               status_in   = STAT_NO_MATCH;
               compares_in = 5'(count_ff);
            end else begin
               compares_in = 5'(CW'(found_pos) + CW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_compare_count = compares_ff;
   assign rsp_entry_total   = total_ff;

endmodule

/* sv/mtfl_checker.sv */
`include "move_to_front_list_table_macros.svh"

module mtfl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input mtfl_pkg::status_type   rsp_status,
   input logic [4:0]             rsp_compare_count
);
   import mtfl_pkg::*;

   // an accepted item always takes the update cycle
   `MTFL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the update cycle lasts one cycle
   `MTFL_ASSERT_NEXT(a_busy_one, clock, reset, busy, !busy)
   // a result strobes right after the update cycle and only then
   `MTFL_ASSERT_NEXT(a_busy_strobe, clock, reset, busy, rsp_strobe)
   `MTFL_ASSERT_NOW(a_strobe_src, clock, reset, rsp_strobe, $past(busy))
   // a full table never reports compares
   `MTFL_ASSERT_NOW(a_full_nocmp, clock, reset, rsp_strobe && rsp_status == STAT_FULL,
                    rsp_compare_count == 5'd0)

endmodule

bind move_to_front_list_table mtfl_checker u_mtfl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_compare_count (rsp_compare_count)
);

/* verif/tb.sv */
module tb;
   import mtfl_pkg::*;

   localparam int DEPTH        = DEFAULT_DEPTH;
   localparam int STALL_LIMIT  = 400;
   localparam int RANDOM_ITEMS = 800;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type status;
      logic [4:0] compare_count;
      logic [4:0] entry_total;
   } list_result_type;

   typedef struct {
      bit                 is_cfg;
      bit                 cfg_value;
      logic [2:0]         op;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic [63:0]        label;
      int                 reps;
      bit                 typed;
      list_result_type    want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [2:0]          req_opcode;
   logic signed [31:0]  req_search_key;
   logic signed [31:0]  req_new_value;
   logic [63:0]         req_new_label;
   logic                rsp_strobe;
   status_type          rsp_status;
   logic [4:0]          rsp_compare_count;
   logic [4:0]          rsp_entry_total;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_move_to_front_enable;

   // shadow copy of the table; labels never reach the result ports
   logic signed [31:0]  shadow_values [DEPTH];
   int                  shadow_count;
   bit                  shadow_mtf;

   list_result_type     awaited_results [$];
   stim_row_type        stim_rows [$];

   int mismatches;
   int items_sent;
   int results_checked;
   int mtf_writes;
   int full_reports;
   int miss_reports;
   int moved_finds;

   always #10 clock = ~clock;

   move_to_front_list_table u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_opcode               (req_opcode),
      .req_search_key           (req_search_key),
      .req_new_value            (req_new_value),
      .req_new_label            (req_new_label),
      .rsp_strobe               (rsp_strobe),
      .rsp_status               (rsp_status),
      .rsp_compare_count        (rsp_compare_count),
      .rsp_entry_total          (rsp_entry_total),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_move_to_front_enable (csr_move_to_front_enable)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int first_hit(input logic signed [31:0] key);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_values[i] == key) begin
            return i;
         end
      end
      return shadow_count;
   endfunction

   task automatic put_entry(input int pos, input logic signed [31:0] value);
      for (int i = shadow_count; i > pos; i--) begin
         shadow_values[i] = shadow_values[i-1];
      end
      shadow_values[pos] = value;
      shadow_count++;
   endtask

   task automatic predict_list_op(input logic [2:0] op, input logic signed [31:0] key,
                                  input logic signed [31:0] value,
                                  output list_result_type res);
      int                 pos;
      logic signed [31:0] hit_value;
      res.status        = STAT_DONE;
      res.compare_count = '0;
      pos = first_hit(key);
      case (op)
         OP_ADD_END, OP_ADD_FRONT: begin
            if (shadow_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               put_entry(op == OP_ADD_END ? shadow_count : 0, value);
            end
         end
         OP_REMOVE: begin
            if (pos >= shadow_count) begin
               res.status = STAT_NO_MATCH;
            end else begin
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_values[i] = shadow_values[i+1];
               end
               shadow_count--;
            end
         end
         OP_INS_BEFORE, OP_INS_AFTER: begin
            // full is checked before the search
            if (shadow_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else if (pos >= shadow_count) begin
               res.status = STAT_NO_MATCH;
            end else begin
               put_entry(op == OP_INS_BEFORE ? pos : pos + 1, value);
            end
         end
         OP_FIND: begin
            if (pos >= shadow_count) begin
               res.status        = STAT_NO_MATCH;
               res.compare_count = 5'(shadow_count);
            end else begin
               res.compare_count = 5'(pos + 1);
               if (shadow_mtf && pos > 0) begin
                  hit_value = shadow_values[pos];
                  for (int i = pos; i > 0; i--) begin
                     shadow_values[i] = shadow_values[i-1];
                  end
                  shadow_values[0] = hit_value;
                  moved_finds++;
               end
            end
         end
         default: ;
      endcase
      if (res.status == STAT_FULL) full_reports++;
      if (res.status == STAT_NO_MATCH) miss_reports++;
      res.entry_total = 5'(shadow_count);
   endtask

   task automatic issue_item(input logic [2:0] op, input logic signed [31:0] key,
                             input logic signed [31:0] value, input logic [63:0] label,
                             input bit typed, input list_result_type want);
      list_result_type res;
      @(negedge clock);
      start          <= 1'b1;
      req_opcode     <= op;
      req_search_key <= key;
      req_new_value  <= value;
      req_new_label  <= label;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_list_op(op, key, value, res);
      if (typed) res = want;
      awaited_results.push_back(res);
      items_sent++;
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_mtf(input bit value);
      wait_drained();
      @(negedge clock);
      csr_valid                <= 1'b1;
      csr_move_to_front_enable <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_mtf = value;
      mtf_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic cfg_row(input bit value);
      stim_row_type row;
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      stim_rows.push_back(row);
   endtask

   task automatic op_row(input logic [2:0] op, input logic signed [31:0] key,
                         input logic signed [31:0] value, input logic [63:0] label,
                         input int reps, input bit typed, input status_type st,
                         input int cnt, input int total);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.op     = op;
      row.key    = key;
      row.value  = value;
      row.label  = label;
      row.reps   = reps;
      row.typed  = typed;
      row.want   = '{st, 5'(cnt), 5'(total)};
      stim_rows.push_back(row);
   endtask

   function automatic logic signed [31:0] small_value();
      logic signed [31:0] v;
      v = $urandom_range(0, 7);
      return v - 4;
   endfunction

   function automatic logic signed [31:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7 && shadow_count > 0) return shadow_values[$urandom_range(0, shadow_count - 1)];
      if (r < 9) return small_value();
      return $urandom;
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return small_value();
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [63:0] pick_label();
      logic [63:0] lab;
      lab = {$urandom, $urandom};
      // a zero byte cuts the stored label short
      if ($urandom_range(0, 3) == 0) lab[8*$urandom_range(0, 7) +: 8] = 8'd0;
      return lab;
   endfunction

   function automatic logic [2:0] pick_op(input bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return r[0] ? OP_SPARE_7 : OP_SPARE_6;
      if (grow) begin
         if (r < 27) return OP_ADD_END;
         if (r < 47) return OP_ADD_FRONT;
         if (r < 59) return OP_INS_BEFORE;
         if (r < 71) return OP_INS_AFTER;
         if (r < 79) return OP_REMOVE;
         return OP_FIND;
      end
      if (r < 8) return OP_ADD_END;
      if (r < 14) return OP_ADD_FRONT;
      if (r < 21) return OP_INS_BEFORE;
      if (r < 28) return OP_INS_AFTER;
      if (r < 65) return OP_REMOVE;
      return OP_FIND;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no item pending", rsp_entry_total, 0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_compare_count !== want.compare_count)
               report_mismatch("compare_count", rsp_compare_count, want.compare_count);
            if (rsp_entry_total !== want.entry_total)
               report_mismatch("entry_total", rsp_entry_total, want.entry_total);
            results_checked++;
         end
      end
   end

   // ends the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      list_result_type no_want;
      logic [2:0]      op;
      bit              grow;
      bit              idling;
      int              done_items;
      int              directed_items;
      bit              phase_mtf [4];

      no_want                  = '0;
      reset                    = 1'b1;
      start                    = 1'b0;
      req_opcode               = '0;
      req_search_key           = '0;
      req_new_value            = '0;
      req_new_label            = '0;
      csr_valid                = 1'b0;
      csr_move_to_front_enable = 1'b0;
      shadow_count             = 0;
      shadow_mtf               = 1'b0;
      mismatches               = 0;
      items_sent               = 0;
      results_checked          = 0;
      mtf_writes               = 0;
      full_reports             = 0;
      miss_reports             = 0;
      moved_finds              = 0;
      for (int i = 0; i < DEPTH; i++) shadow_values[i] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: empty table, extremes, unused opcodes, full table
      cfg_row(1'b0);
      op_row(OP_FIND, 5, 0, 64'h0, 1, 1, STAT_NO_MATCH, 0, 0);
      op_row(OP_REMOVE, 5, 0, 64'h0, 1, 1, STAT_NO_MATCH, 0, 0);
      op_row(OP_INS_BEFORE, 5, 1, 64'h41, 1, 1, STAT_NO_MATCH, 0, 0);
      op_row(OP_INS_AFTER, 5, 1, 64'h41, 1, 1, STAT_NO_MATCH, 0, 0);
      op_row(OP_ADD_END, 32'sh7fff_ffff, 32'sh7fff_ffff, '1, 1, 1, STAT_DONE, 0, 1);
      op_row(OP_ADD_FRONT, 0, 32'sh8000_0000, 64'h0, 1, 1, STAT_DONE, 0, 2);
      op_row(OP_ADD_END, 0, 0, 64'h0011_2233_0044_5566, 1, 1, STAT_DONE, 0, 3);
      op_row(OP_INS_AFTER, 32'sh8000_0000, -1, 64'h4241, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_INS_BEFORE, 0, 9, 64'h43, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_FIND, 32'sh7fff_ffff, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_SPARE_6, 0, 4, '1, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_SPARE_7, -1, 4, '1, 1, 0, STAT_DONE, 0, 0);
      cfg_row(1'b1);
      op_row(OP_FIND, 0, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);
      // second find hits the head, order stays
      op_row(OP_FIND, 0, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_FIND, 12345, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_ADD_END, 0, 3, 64'h44, 13, 0, STAT_DONE, 0, 0);
      op_row(OP_ADD_FRONT, 0, 8, 64'h45, 1, 1, STAT_FULL, 0, 16);
      op_row(OP_INS_BEFORE, 777, 8, 64'h46, 1, 1, STAT_FULL, 0, 16);
      op_row(OP_INS_AFTER, 3, 8, 64'h47, 1, 1, STAT_FULL, 0, 16);
      op_row(OP_FIND, 555, 0, 64'h0, 1, 1, STAT_NO_MATCH, 16, 16);
      op_row(OP_REMOVE, 3, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);
      op_row(OP_REMOVE, 32'sh7fff_ffff, 0, 64'h0, 1, 0, STAT_DONE, 0, 0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            write_mtf(stim_rows[i].cfg_value);
         end else begin
            repeat (stim_rows[i].reps)
               issue_item(stim_rows[i].op, stim_rows[i].key, stim_rows[i].value,
                          stim_rows[i].label, stim_rows[i].typed, stim_rows[i].want);
         end
      end
      directed_items = items_sent;

      // random part in four phases, move-to-front toggled between them
      phase_mtf = '{1'b0, 1'b1, 1'b0, 1'b1};
      grow      = 1'b1;
      idling    = 1'b1;
      for (int p = 0; p < 4; p++) begin
         write_mtf(phase_mtf[p]);
         done_items = 0;
         while (done_items < RANDOM_ITEMS / 4) begin
            if ($urandom_range(0, 29) == 0) grow = ~grow;
            if ($urandom_range(0, 49) == 0) idling = ~idling;
            // no idling in the closing stretch
            if (idling && !(p == 3 && done_items >= 50) && $urandom_range(0, 5) == 0)
               hold_off($urandom_range(1, 16));
            if ($urandom_range(0, 99) == 0) wait_drained();
            op = pick_op(grow);
            issue_item(op, pick_key(), pick_value(), pick_label(), 1'b0, no_want);
            if (op != OP_SPARE_6 && op != OP_SPARE_7) done_items++;
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("sent %0d items (%0d directed), checked %0d results, %0d mode writes",
               items_sent, directed_items, results_checked, mtf_writes);
      $display("full %0d times, no match %0d times, %0d finds moved an entry to the head",
               full_reports, miss_reports, moved_finds);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
